// File: rtl/btsl_pkg.sv
// btsl_pkg: shared types, sizes and the key table for the topic subscriber lists
// used by byte_topic_subscriber_lists and byte_topic_subscriber_lists_test; no dependencies
`timescale 1ns / 1ps

package btsl_pkg;

  // list and key sizing
  localparam int MAX_SUBS  = 8;
  localparam int KEY_COUNT = 256;

  localparam int KEY_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int IDX_W  = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam int LEN_W  = $clog2(MAX_SUBS + 1);
  localparam int CNT_W  = $clog2(KEY_COUNT + 1);
  localparam int ADDR_W = $clog2(KEY_COUNT * MAX_SUBS);
  localparam int ID_W   = 16;

  // operation codes on the input tuser
  typedef enum logic [1:0] {
    OP_SUB       = 2'd0,
    OP_UNSUB     = 2'd1,
    OP_UNSUB_ALL = 2'd2,
    OP_MATCH     = 2'd3
  } opcode_e;

  // result kinds on the output tuser
  typedef enum logic [1:0] {
    RK_MATCH     = 2'd0,
    RK_SUB       = 2'd1,
    RK_UNSUB     = 2'd2,
    RK_UNSUB_ALL = 2'd3
  } kind_e;

  // status codes
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FIRST     = 3'd1,
    STS_BAD_LEN   = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN_RD,
    S_LEN_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LEN_WR,
    S_NEXT_KEY,
    S_EMIT_RD,
    S_EMIT,
    S_OUT
  } state_e;

  // topic byte to key, reduced modulo the key count at elaboration
  typedef logic [255:0][KEY_W-1:0] key_lut_t;

  function automatic key_lut_t key_table();
    key_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = KEY_W'(i % KEY_COUNT);
    end
    return t;
  endfunction

  localparam key_lut_t KEY_LUT = key_table();

  // entry address of slot idx in the list of key
  function automatic logic [ADDR_W-1:0] store_addr(logic [KEY_W-1:0] key,
                                                   logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(key) * ADDR_W'(MAX_SUBS);
    return base + ADDR_W'(idx);
  endfunction

endpackage

// File: rtl/btsl_ram.sv
// btsl_ram: generic single write port, single read port ram with registered read
// no package dependencies
`timescale 1ns / 1ps

module btsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/byte_topic_subscriber_lists.sv
// byte_topic_subscriber_lists: per-key ordered subscriber lists with subscribe,
// unsubscribe, unsubscribe-all and match; uses btsl_pkg and btsl_ram
`timescale 1ns / 1ps
//
// channel  | direction | tuser          | tdata (lowest bit up)                    | tlast
// ---------+-----------+----------------+------------------------------------------+------------
// s_axis   | in        | opcode [1:0]   | topic_byte, topic_length, subscriber_id  | -
// m_axis   | out       | result_kind    | status, matched_id, released_count, 0000 | last_of_run
//
// One sequencer walks the lists through a length ram (with reset-cleared valid
// bits per key) and an entry ram, one entry access per cycle, read data registered.
// Subscribe and match work on the list of one key; an empty match message gives no result.
// Unsubscribe scans the list of its key and, when the id is found, shifts the rest down.
// Unsubscribe-all visits every one of the 256 keys, scanning each list and removing
// the first occurrence of the id where it is found.
// Reset is asynchronous and needs no clearing pass.
// A stalled output holds the sequencer at its next result; s_axis_tready is high
// only between operations, also while the last result waits in the output register.

module byte_topic_subscriber_lists (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // topic_byte[7:0], topic_length[15:8], subscriber_id[31:16]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status[2:0], matched_id[18:3], released_count[27:19]
  output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
  output logic        m_axis_tlast    // last_of_run
);

  localparam int KW = btsl_pkg::KEY_W;
  localparam int IW = btsl_pkg::IDX_W;
  localparam int LW = btsl_pkg::LEN_W;
  localparam int CW = btsl_pkg::CNT_W;
  localparam int AW = btsl_pkg::ADDR_W;
  localparam int DW = btsl_pkg::ID_W;

  btsl_pkg::state_e  state_q, state_d;
  btsl_pkg::opcode_e op_q, op_d;
  btsl_pkg::status_e sts_q, sts_d;
  logic [KW-1:0]     key_q, key_d;
  logic [DW-1:0]     id_q, id_d;
  logic [LW-1:0]     n_q, n_d;
  logic [LW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [btsl_pkg::KEY_COUNT-1:0] valid_q, valid_d;

  // output register
  logic              out_valid_q, out_valid_d;
  btsl_pkg::kind_e   out_kind_q, out_kind_d;
  btsl_pkg::status_e out_sts_q, out_sts_d;
  logic [DW-1:0]     out_id_q, out_id_d;
  logic [CW-1:0]     out_cnt_q, out_cnt_d;
  logic              out_last_q, out_last_d;

  // ram ports
  logic          len_we, len_re;
  logic [LW-1:0] len_wdata, len_rdata;
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [DW-1:0] st_wdata, st_rdata;

  // input fields
  btsl_pkg::opcode_e in_op;
  logic [7:0]        in_byte;
  logic [7:0]        in_len;
  logic [DW-1:0]     in_id;

  logic          accept;
  logic          out_free;
  logic [LW-1:0] n_cur;
  logic [LW:0]   idx_p1;
  logic [LW:0]   idx_p2;
  logic          len_bad;

  assign in_op   = btsl_pkg::opcode_e'(s_axis_tuser);
  assign in_byte = s_axis_tdata[7:0];
  assign in_len  = s_axis_tdata[15:8];
  assign in_id   = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == btsl_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign len_bad       = (in_len != 8'd1);

  // length of the current key, empty until first written
  assign n_cur  = valid_q[key_q] ? len_rdata : '0;
  assign idx_p1 = {1'b0, idx_q} + (LW+1)'(1);
  assign idx_p2 = {1'b0, idx_q} + (LW+1)'(2);

  // list lengths
  btsl_ram #(
    .WIDTH(LW),
    .DEPTH(btsl_pkg::KEY_COUNT)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (len_we),
    .waddr_i(key_q),
    .wdata_i(len_wdata),
    .re_i   (len_re),
    .raddr_i(key_q),
    .rdata_o(len_rdata)
  );

  // list entries
  btsl_ram #(
    .WIDTH(DW),
    .DEPTH(btsl_pkg::KEY_COUNT * btsl_pkg::MAX_SUBS)
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btsl_pkg::S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sts_q      <= sts_d;
    key_q      <= key_d;
    id_q       <= id_d;
    n_q        <= n_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    out_kind_q <= out_kind_d;
    out_sts_q  <= out_sts_d;
    out_id_q   <= out_id_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sts_d       = sts_q;
    key_d       = key_q;
    id_d        = id_q;
    n_d         = n_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_sts_d   = out_sts_q;
    out_id_d    = out_id_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    len_we      = 1'b0;
    len_re      = 1'b0;
    len_wdata   = n_q;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_waddr    = btsl_pkg::store_addr(key_q, idx_q[IW-1:0]);
    st_wdata    = st_rdata;
    st_raddr    = btsl_pkg::store_addr(key_q, idx_q[IW-1:0]);

    unique case (state_q)
      btsl_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = in_op;
          id_d  = in_id;
          key_d = btsl_pkg::KEY_LUT[in_byte];
          cnt_d = '0;
          idx_d = '0;
          state_d = btsl_pkg::S_LEN_RD;
          case (in_op) inside
            btsl_pkg::OP_SUB, btsl_pkg::OP_UNSUB: begin
              if (len_bad) begin
                sts_d   = btsl_pkg::STS_BAD_LEN;
                state_d = btsl_pkg::S_OUT;
              end
            end
            btsl_pkg::OP_UNSUB_ALL: begin
              key_d = '0;
            end
            default: begin
              if (in_len == 8'd0) begin
                state_d = btsl_pkg::S_IDLE;
              end
            end
          endcase
        end
      end

      btsl_pkg::S_LEN_RD: begin
        len_re  = 1'b1;
        state_d = btsl_pkg::S_LEN_CHK;
      end

      btsl_pkg::S_LEN_CHK: begin
        n_d   = n_cur;
        idx_d = '0;
        case (op_q)
          btsl_pkg::OP_SUB: begin
            if (n_cur >= LW'(btsl_pkg::MAX_SUBS)) begin
              sts_d = btsl_pkg::STS_FULL;
            end else begin
              st_we          = 1'b1;
              st_waddr       = btsl_pkg::store_addr(key_q, n_cur[IW-1:0]);
              st_wdata       = id_q;
              len_we         = 1'b1;
              len_wdata      = n_cur + LW'(1);
              valid_d[key_q] = 1'b1;
              sts_d = (n_cur == '0) ? btsl_pkg::STS_FIRST : btsl_pkg::STS_OK;
            end
            state_d = btsl_pkg::S_OUT;
          end
          btsl_pkg::OP_MATCH: begin
            state_d = (n_cur == '0) ? btsl_pkg::S_IDLE : btsl_pkg::S_EMIT_RD;
          end
          default: begin
            if (n_cur != '0) begin
              state_d = btsl_pkg::S_SCAN_RD;
            end else if (op_q == btsl_pkg::OP_UNSUB) begin
              sts_d   = btsl_pkg::STS_NOT_FOUND;
              state_d = btsl_pkg::S_OUT;
            end else begin
              state_d = btsl_pkg::S_NEXT_KEY;
            end
          end
        endcase
      end

      // search for the first matching entry
      btsl_pkg::S_SCAN_RD: begin
        st_re   = 1'b1;
        state_d = btsl_pkg::S_SCAN_CHK;
      end

      btsl_pkg::S_SCAN_CHK: begin
        if (st_rdata == id_q) begin
          state_d = (idx_p1 < {1'b0, n_q}) ? btsl_pkg::S_SHIFT_RD : btsl_pkg::S_LEN_WR;
        end else if (idx_p1 < {1'b0, n_q}) begin
          idx_d   = idx_p1[LW-1:0];
          state_d = btsl_pkg::S_SCAN_RD;
        end else if (op_q == btsl_pkg::OP_UNSUB) begin
          sts_d   = btsl_pkg::STS_NOT_FOUND;
          state_d = btsl_pkg::S_OUT;
        end else begin
          state_d = btsl_pkg::S_NEXT_KEY;
        end
      end

      // close the gap, moving each later entry down one slot
      btsl_pkg::S_SHIFT_RD: begin
        st_re    = 1'b1;
        st_raddr = btsl_pkg::store_addr(key_q, idx_p1[IW-1:0]);
        state_d  = btsl_pkg::S_SHIFT_WR;
      end

      btsl_pkg::S_SHIFT_WR: begin
        st_we    = 1'b1;
        st_wdata = st_rdata;
        idx_d    = idx_p1[LW-1:0];
        state_d  = (idx_p2 < {1'b0, n_q}) ? btsl_pkg::S_SHIFT_RD : btsl_pkg::S_LEN_WR;
      end

      btsl_pkg::S_LEN_WR: begin
        len_we    = 1'b1;
        len_wdata = n_q - LW'(1);
        if (op_q == btsl_pkg::OP_UNSUB) begin
          sts_d   = (n_q == LW'(1)) ? btsl_pkg::STS_FIRST : btsl_pkg::STS_OK;
          state_d = btsl_pkg::S_OUT;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = btsl_pkg::S_NEXT_KEY;
        end
      end

      // unsubscribe-all walks every key
      btsl_pkg::S_NEXT_KEY: begin
        if (key_q == KW'(btsl_pkg::KEY_COUNT - 1)) begin
          sts_d   = btsl_pkg::STS_OK;
          state_d = btsl_pkg::S_OUT;
        end else begin
          key_d   = key_q + KW'(1);
          state_d = btsl_pkg::S_LEN_RD;
        end
      end

      // match results, one per entry
      btsl_pkg::S_EMIT_RD: begin
        st_re   = 1'b1;
        state_d = btsl_pkg::S_EMIT;
      end

      btsl_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = btsl_pkg::RK_MATCH;
          out_sts_d   = btsl_pkg::STS_OK;
          out_id_d    = st_rdata;
          out_cnt_d   = '0;
          out_last_d  = (idx_p1 == {1'b0, n_q});
          if (idx_p1 == {1'b0, n_q}) begin
            state_d = btsl_pkg::S_IDLE;
          end else begin
            idx_d   = idx_p1[LW-1:0];
            state_d = btsl_pkg::S_EMIT_RD;
          end
        end
      end

      // single status result
      btsl_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = sts_q;
          out_id_d    = '0;
          out_last_d  = 1'b1;
          out_cnt_d   = (op_q == btsl_pkg::OP_UNSUB_ALL) ? cnt_q : '0;
          case (op_q)
            btsl_pkg::OP_SUB:       out_kind_d = btsl_pkg::RK_SUB;
            btsl_pkg::OP_UNSUB:     out_kind_d = btsl_pkg::RK_UNSUB;
            default:                out_kind_d = btsl_pkg::RK_UNSUB_ALL;
          endcase
          state_d = btsl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = btsl_pkg::S_IDLE;
      end
    endcase
  end

  // output channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, 9'(out_cnt_q), out_id_q, out_sts_q};

endmodule

// File: tb/sv/byte_topic_subscriber_lists_test.sv
// byte_topic_subscriber_lists_test: self-checking bench for the per-key subscriber lists,
// directed cases then weighted random traffic against a local list predictor
// depends on btsl_pkg and byte_topic_subscriber_lists
`timescale 1ns / 1ps

module byte_topic_subscriber_lists_test;
  import btsl_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int TAIL_CYCLES = 64;

  // one result as the block should send it
  typedef struct packed {
    kind_e          kind;
    status_e        status;
    logic [ID_W-1:0] id;
    logic [CNT_W-1:0] released;
    logic           last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // topic_byte[7:0], topic_length[15:8], subscriber_id[31:16]
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // status[2:0], matched_id[18:3], released_count[27:19]
  logic [1:0]  m_axis_tuser;        // result_kind[1:0]
  logic        m_axis_tlast;        // last_of_run

  // local copy of the lists
  int unsigned     list_fill [KEY_COUNT];
  logic [ID_W-1:0] list_ids  [KEY_COUNT][MAX_SUBS];

  result_t         pending_results[$];
  logic [ID_W-1:0] id_pool[12];
  int unsigned     src_idle_pct = 11;
  int unsigned     sink_idle_pct = 77;
  int unsigned     mismatch_count = 0;
  int unsigned     stall_cycles = 0;

  byte_topic_subscriber_lists u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // remove the first occurrence of an id from one key, closing the gap
  function automatic bit drop_first_id(int unsigned key, logic [ID_W-1:0] id);
    int unsigned pos;
    pos = list_fill[key];
    for (int unsigned i = 0; i < list_fill[key]; i++) begin
      if (list_ids[key][i] == id) begin
        pos = i;
        break;
      end
    end
    if (pos >= list_fill[key]) return 1'b0;
    for (int unsigned i = pos; i + 1 < list_fill[key]; i++) begin
      list_ids[key][i] = list_ids[key][i + 1];
    end
    list_fill[key]--;
    return 1'b1;
  endfunction

  // update the lists for one accepted request and queue the results it causes
  function automatic void apply_to_lists(opcode_e op, logic [7:0] topic_byte,
                                         logic [7:0] topic_len, logic [ID_W-1:0] id);
    int unsigned key;
    int unsigned fill;
    int unsigned released;
    status_e     st;
    key  = topic_byte % KEY_COUNT;
    fill = list_fill[key];
    case (op)
      OP_SUB: begin
        if (topic_len != 8'd1) begin
          st = STS_BAD_LEN;
        end else if (fill >= MAX_SUBS) begin
          st = STS_FULL;
        end else begin
          list_ids[key][fill] = id;
          list_fill[key] = fill + 1;
          st = (fill == 0) ? STS_FIRST : STS_OK;
        end
        pending_results.push_back('{RK_SUB, st, '0, '0, 1'b1});
      end
      OP_UNSUB: begin
        if (topic_len != 8'd1) st = STS_BAD_LEN;
        else if (!drop_first_id(key, id)) st = STS_NOT_FOUND;
        else st = (list_fill[key] == 0) ? STS_FIRST : STS_OK;
        pending_results.push_back('{RK_UNSUB, st, '0, '0, 1'b1});
      end
      OP_UNSUB_ALL: begin
        released = 0;
        for (int unsigned k = 0; k < KEY_COUNT; k++) begin
          if (drop_first_id(k, id)) released++;
        end
        pending_results.push_back('{RK_UNSUB_ALL, STS_OK, '0, CNT_W'(released), 1'b1});
      end
      default: begin
        if (topic_len != 8'd0) begin
          for (int unsigned i = 0; i < fill; i++) begin
            pending_results.push_back('{RK_MATCH, STS_OK, list_ids[key][i], '0,
                                        (i + 1 == fill)});
          end
        end
      end
    endcase
  endfunction

  // one request transfer, entered and left at a falling edge
  task automatic issue_request(opcode_e op, logic [7:0] topic_byte, logic [7:0] topic_len,
                               logic [ID_W-1:0] id);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {id, topic_len, topic_byte};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_to_lists(op, topic_byte, topic_len, id);
    @(negedge clk_i);
  endtask

  // sender holds off until every queued result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_idling(int unsigned src_pct, int unsigned sink_pct);
    drain_results();
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // compare each result transfer with the oldest queued one
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind_e'(m_axis_tuser), status_e'(m_axis_tdata[2:0]), m_axis_tdata[18:3],
              m_axis_tdata[27:19], m_axis_tlast};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d data %08h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("result_kind got %0d exp %0d", got.kind, want.kind));
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d exp %0d", got.status, want.status));
        if (got.id !== want.id)
          report_mismatch($sformatf("matched_id got %04h exp %04h", got.id, want.id));
        if (got.released !== want.released)
          report_mismatch($sformatf("released_count got %0d exp %0d",
                                    got.released, want.released));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_of_run got %0b exp %0b", got.last, want.last));
        if (m_axis_tdata[31:28] !== 4'b0000)
          report_mismatch($sformatf("tdata padding got %01h", m_axis_tdata[31:28]));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // first subscriber, later subscriber, bad lengths
  task automatic test_subscribe_status();
    issue_request(OP_SUB, 8'h00, 8'd1, 16'h0000);
    issue_request(OP_SUB, 8'h00, 8'd1, 16'hFFFF);
    issue_request(OP_SUB, 8'hFF, 8'd1, 16'hA5A5);
    issue_request(OP_SUB, 8'h0A, 8'd0, 16'h1234);
    issue_request(OP_SUB, 8'h0A, 8'd255, 16'h1234);
  endtask

  // one id on every eighth key and the top key, then removed everywhere at once
  task automatic test_release_every_key();
    for (int k = 0; k < 256; k += 8) begin
      issue_request(OP_SUB, 8'(k), 8'd1, 16'h5A5A);
    end
    issue_request(OP_SUB, 8'hFF, 8'd1, 16'h5A5A);
    issue_request(OP_UNSUB_ALL, 8'($urandom), 8'($urandom), 16'h5A5A);
  endtask

  // fill one list with duplicates, then one more
  task automatic test_full_list();
    issue_request(OP_SUB, 8'h7E, 8'd1, 16'd1);
    issue_request(OP_SUB, 8'h7E, 8'd1, 16'd2);
    issue_request(OP_SUB, 8'h7E, 8'd1, 16'd3);
    issue_request(OP_SUB, 8'h7E, 8'd1, 16'd2);
    for (int i = 4; i <= 8; i++) begin
      issue_request(OP_SUB, 8'h7E, 8'd1, 16'(i));
    end
  endtask

  // full list, empty message, empty list, long message
  task automatic test_match();
    issue_request(OP_MATCH, 8'h7E, 8'd1, 16'h0000);
    issue_request(OP_MATCH, 8'h7E, 8'd0, 16'hFFFF);
    issue_request(OP_MATCH, 8'h33, 8'd255, 16'h0000);
    issue_request(OP_MATCH, 8'h00, 8'd255, 16'h0000);
  endtask

  // first duplicate removed, absent id, bad length, list emptied
  task automatic test_unsubscribe();
    issue_request(OP_UNSUB, 8'h7E, 8'd1, 16'd2);
    issue_request(OP_UNSUB, 8'h7E, 8'd1, 16'd9);
    issue_request(OP_UNSUB, 8'h7E, 8'd2, 16'd3);
    issue_request(OP_UNSUB, 8'h00, 8'd1, 16'h0000);
    issue_request(OP_UNSUB, 8'h00, 8'd1, 16'hFFFF);
    issue_request(OP_MATCH, 8'h7E, 8'd1, 16'h0000);
  endtask

  // id present on one key, id present nowhere
  task automatic test_unsubscribe_all();
    issue_request(OP_UNSUB_ALL, 8'h00, 8'd0, 16'd2);
    issue_request(OP_UNSUB_ALL, 8'hFF, 8'd255, 16'hBEEF);
  endtask

  // mostly well-formed requests on a few hot keys and ids, with some noise
  task automatic test_random_traffic(int unsigned n_items);
    opcode_e         op;
    logic [7:0]      topic_byte;
    logic [7:0]      topic_len;
    logic [ID_W-1:0] id;
    int unsigned     pick;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_SUB;
      else if (pick < 65) op = OP_UNSUB;
      else if (pick < 95) op = OP_MATCH;
      else op = OP_UNSUB_ALL;
      topic_byte = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7) * 36);
      id = ($urandom_range(4) == 0) ? 16'($urandom) : id_pool[$urandom_range(11)];
      if (op == OP_MATCH) topic_len = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
      else topic_len = ($urandom_range(7) == 0) ? 8'($urandom) : 8'd1;
      issue_request(op, topic_byte, topic_len, id);
      if ($urandom_range(24) == 0) drain_results();
    end
  endtask

  initial begin
    foreach (list_fill[k]) list_fill[k] = 0;
    foreach (id_pool[j]) id_pool[j] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_subscribe_status();
    test_release_every_key();
    test_full_list();
    test_match();
    test_unsubscribe();
    test_unsubscribe_all();
    test_random_traffic(65);
    set_idling(77, 11);
    test_random_traffic(65);
    set_idling(0, 0);
    test_random_traffic(60);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: byte_topic_subscriber_lists.f
rtl/btsl_pkg.sv
rtl/btsl_ram.sv
rtl/byte_topic_subscriber_lists.sv
tb/sv/byte_topic_subscriber_lists_test.sv
